/* rtl/bpc_pkg.sv */
// Shared types and constants of the barometric compensation core.
// Holds field widths, scaling shifts, register indexes and the words
// passed between the pipeline sections. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Port field widths
    localparam int RAW_W    = 24;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;
    localparam int NUM_REGS = 6;
    localparam int P_W      = 32;
    localparam int T_W      = 19;

    // Scaling shifts of the compensation formula
    localparam int SH_REF       = 8;
    localparam int SH_TEMP      = 23;
    localparam int SH_T2        = 31;
    localparam int SH_OFF_BASE  = 16;
    localparam int SH_SENS_BASE = 15;
    localparam int SH_OFF_TC    = 7;
    localparam int SH_SENS_TC   = 8;
    localparam int SH_PSENS     = 21;
    localparam int SH_POUT      = 15;

    // Internal widths
    localparam int DT_W   = RAW_W + 1;            // dT, signed
    localparam int TC_W   = DT_W + CFG_W + 1;     // dT times a coefficient
    localparam int DD_W   = 2 * DT_W;             // dT squared
    localparam int X_W    = 20;                   // temperatures and deltas
    localparam int SQ_W   = 2 * X_W;              // squared deltas, corrections
    localparam int OFF_W  = 40;
    localparam int SENS_W = 40;
    localparam int SPLIT  = 20;                   // low part of SENS in the product
    localparam int PL_W   = RAW_W + SPLIT;
    localparam int PH_W   = RAW_W + 1 + SENS_W - SPLIT;
    localparam int PROD_W = 64;
    localparam int Q_W    = PROD_W - SH_PSENS + 1;

    // Temperature thresholds, in 0.01 degC
    localparam logic signed [X_W-1:0] TEMP_BASE     = X_W'(2000);
    localparam logic signed [X_W-1:0] TEMP_LOW_BIAS = X_W'(1500);
    localparam logic signed [X_W-1:0] COLD_BIAS     = TEMP_BASE + TEMP_LOW_BIAS;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SENS    = 3'd0,
        REG_OFF     = 3'd1,
        REG_SENS_TC = 3'd2,
        REG_OFF_TC  = 3'd3,
        REG_TREF    = 3'd4,
        REG_TSLOPE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] sens_coeff;
        logic [CFG_W-1:0] offset_coeff;
        logic [CFG_W-1:0] sens_temp_coeff;
        logic [CFG_W-1:0] offset_temp_coeff;
        logic [CFG_W-1:0] ref_temp;
        logic [CFG_W-1:0] temp_slope_coeff;
    } t_cfg;

    // First-order results handed to the second-order section
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [X_W-1:0]    temp1;
        logic signed [X_W-1:0]    t2;
        logic signed [X_W-1:0]    x;
        logic signed [X_W-1:0]    y;
        logic signed [OFF_W-1:0]  off1;
        logic signed [SENS_W-1:0] sens1;
        logic                     cold;
        logic                     vcold;
    } t_fo_word;

    // Corrected terms handed to the pressure section
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [X_W-1:0]    temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
    } t_so_word;

endpackage

`default_nettype wire

/* rtl/bpc_if.sv */
// Channel interfaces of the compensation core: sample input, result output
// and configuration write channel. Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bpc_in_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] pressure_raw;
    logic [RAW_W-1:0] temp_raw;
    modport source (output valid, output pressure_raw, output temp_raw, input ready);
    modport sink   (input valid, input pressure_raw, input temp_raw, output ready);
endinterface

interface bpc_out_if;
    import bpc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [P_W-1:0] pressure;
    logic signed [T_W-1:0] temperature;
    modport source (output valid, output pressure, output temperature, input ready);
    modport sink   (input valid, input pressure, input temperature, output ready);
endinterface

interface bpc_cfg_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/baro_pressure_temp_compensation_core.sv */
// Barometric pressure and temperature compensation core, top level.
// Raw conversion words enter on i_in (pressure_raw, temp_raw, 24 bits each).
// One result word leaves on o_out per input word: pressure in 0.01 mbar
// (signed 32 bits, saturated) and temperature in 0.01 degC (signed 19 bits).
// The six calibration words are written on i_cfg at indexes 0 to 5 (sens,
// offset, sens temp coeff, offset temp coeff, reference temp, temp slope);
// writes at other indexes are dropped. i_cfg.ready is always high. Write
// calibration only while no word is in flight.
// Pipeline: ten register stages, three for first-order terms, three for
// second-order corrections, four for pressure product, scaling and output
// register. Throughput: one word per cycle while o_out.ready is high;
// every multiplier is pipelined.
// Reset (synchronous, active low) empties the pipeline and clears all
// calibration words to zero. When the receiver stalls, the output word holds
// and upstream stages keep filling empty slots until the pipeline is full;
// only then does i_in.ready fall.
// Depends on bpc_pkg, bpc_if and the bpc_* section modules.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpc_in_if.sink     i_in,
    bpc_out_if.source  o_out,
    bpc_cfg_if.sink    i_cfg
);
    import bpc_pkg::*;

    t_cfg     w_cfg;
    t_fo_word w_fo_word;
    t_so_word w_so_word;
    logic     w_fo_vld;
    logic     w_fo_rdy;
    logic     w_so_vld;
    logic     w_so_rdy;

    bpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_cfg.valid),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_rdy   (i_cfg.ready),
        .o_cfg   (w_cfg)
    );

    bpc_first_order u_first_order (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_vld          (i_in.valid),
        .o_rdy          (i_in.ready),
        .i_pressure_raw (i_in.pressure_raw),
        .i_temp_raw     (i_in.temp_raw),
        .o_vld          (w_fo_vld),
        .i_rdy          (w_fo_rdy),
        .o_word         (w_fo_word)
    );

    bpc_second_order u_second_order (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_fo_vld),
        .o_rdy   (w_fo_rdy),
        .i_word  (w_fo_word),
        .o_vld   (w_so_vld),
        .i_rdy   (w_so_rdy),
        .o_word  (w_so_word)
    );

    bpc_pressure u_pressure (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (w_so_vld),
        .o_rdy         (w_so_rdy),
        .i_word        (w_so_word),
        .o_vld         (o_out.valid),
        .i_rdy         (o_out.ready),
        .o_pressure    (o_out.pressure),
        .o_temperature (o_out.temperature)
    );

endmodule

`default_nettype wire

/* rtl/bpc_cfg_regs.sv */
// Calibration register file of the compensation core.
// Decodes configuration writes into six 16-bit words. Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    input  logic [bpc_pkg::IDX_W-1:0] i_idx,
    input  logic [bpc_pkg::CFG_W-1:0] i_data,
    output logic                      o_rdy,
    output bpc_pkg::t_cfg             o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Always take the write word
    assign o_rdy = 1'b1;
    assign o_cfg = r_cfg;

    // Decode the index; drop writes beyond the register list
    always_comb begin
        n_cfg = r_cfg;
        if (i_vld) begin
            case (i_idx)
                REG_SENS:    n_cfg.sens_coeff        = i_data;
                REG_OFF:     n_cfg.offset_coeff      = i_data;
                REG_SENS_TC: n_cfg.sens_temp_coeff   = i_data;
                REG_OFF_TC:  n_cfg.offset_temp_coeff = i_data;
                REG_TREF:    n_cfg.ref_temp          = i_data;
                REG_TSLOPE:  n_cfg.temp_slope_coeff  = i_data;
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    a_slope_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld && (i_idx == REG_TSLOPE) |=> r_cfg.temp_slope_coeff == $past(i_data))
        else $error("temperature slope write not stored");

    a_unknown_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld && (i_idx >= IDX_W'(NUM_REGS)) |=> $stable(r_cfg))
        else $error("write beyond register list changed a register");

endmodule

`default_nettype wire

/* rtl/bpc_first_order.sv */
// First-order section: dT, products with the calibration words, TEMP,
// OFF, SENS and the second-order deltas. Three register stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_first_order (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bpc_pkg::t_cfg             i_cfg,
    input  logic                      i_vld,
    output logic                      o_rdy,
    input  logic [bpc_pkg::RAW_W-1:0] i_pressure_raw,
    input  logic [bpc_pkg::RAW_W-1:0] i_temp_raw,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output bpc_pkg::t_fo_word         o_word
);
    import bpc_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] w_adv;

    // Stage A: temperature difference
    logic [RAW_W-1:0]       r_a_d1;
    logic signed [DT_W-1:0] r_a_dt;
    logic signed [DT_W-1:0] n_a_dt;

    // Stage B: products of dT
    logic [RAW_W-1:0]       r_b_d1;
    logic signed [TC_W-1:0] r_b_pt;
    logic signed [TC_W-1:0] r_b_po;
    logic signed [TC_W-1:0] r_b_ps;
    logic signed [DD_W-1:0] r_b_pd;
    logic signed [TC_W-1:0] n_b_pt;
    logic signed [TC_W-1:0] n_b_po;
    logic signed [TC_W-1:0] n_b_ps;
    logic signed [DD_W-1:0] n_b_pd;

    // Stage C: scaled first-order terms
    t_fo_word                 r_c;
    t_fo_word                 n_c;
    logic signed [X_W-1:0]    w_x;
    logic signed [X_W-1:0]    w_y;
    logic signed [OFF_W-1:0]  w_off_base;
    logic signed [SENS_W-1:0] w_sens_base;

    // Advance a stage when it is empty or the next one moves
    always_comb begin
        w_adv[2] = !r_vld[2] || i_rdy;
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
    end

    assign o_rdy  = w_adv[0];
    assign o_vld  = r_vld[2];
    assign o_word = r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    // dT = D2 - C5 * 2^8
    assign n_a_dt = $signed({1'b0, i_temp_raw})
                  - $signed({1'b0, i_cfg.ref_temp, {SH_REF{1'b0}}});

    // Multiply dT by the three temperature coefficients and by itself
    assign n_b_pt = r_a_dt * $signed({1'b0, i_cfg.temp_slope_coeff});
    assign n_b_po = r_a_dt * $signed({1'b0, i_cfg.offset_temp_coeff});
    assign n_b_ps = r_a_dt * $signed({1'b0, i_cfg.sens_temp_coeff});
    assign n_b_pd = r_a_dt * r_a_dt;

    // Scale the products; x and y are TEMP relative to the two thresholds
    assign w_x = X_W'(r_b_pt >>> SH_TEMP);
    assign w_y = w_x + COLD_BIAS;
    assign w_off_base  = $signed({{(OFF_W-CFG_W-SH_OFF_BASE){1'b0}},
                                  i_cfg.offset_coeff, {SH_OFF_BASE{1'b0}}});
    assign w_sens_base = $signed({{(SENS_W-CFG_W-SH_SENS_BASE){1'b0}},
                                  i_cfg.sens_coeff, {SH_SENS_BASE{1'b0}}});

    always_comb begin
        n_c.d1    = r_b_d1;
        n_c.x     = w_x;
        n_c.y     = w_y;
        n_c.temp1 = w_x + TEMP_BASE;
        n_c.t2    = X_W'(r_b_pd >>> SH_T2);
        n_c.off1  = w_off_base + OFF_W'(r_b_po >>> SH_OFF_TC);
        n_c.sens1 = w_sens_base + SENS_W'(r_b_ps >>> SH_SENS_TC);
        n_c.cold  = w_x[X_W-1];
        n_c.vcold = w_y[X_W-1];
    end

    // Payload registers load on advance
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_a_d1 <= i_pressure_raw;
            r_a_dt <= n_a_dt;
        end
        if (w_adv[1]) begin
            r_b_d1 <= r_a_d1;
            r_b_pt <= n_b_pt;
            r_b_po <= n_b_po;
            r_b_ps <= n_b_ps;
            r_b_pd <= n_b_pd;
        end
        if (w_adv[2]) begin
            r_c <= n_c;
        end
    end

    a_cold_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] && r_c.vcold |-> r_c.cold)
        else $error("below -15.00 degC flagged without below 20.00 degC");

endmodule

`default_nettype wire

/* rtl/bpc_second_order.sv */
// Second-order section: squares of the temperature deltas, corrections
// T2, OFF2, SENS2 and the corrected TEMP, OFF, SENS. Three register stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_second_order (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  bpc_pkg::t_fo_word i_word,
    output logic              o_vld,
    input  logic              i_rdy,
    output bpc_pkg::t_so_word o_word
);
    import bpc_pkg::*;

    localparam logic signed [X_W-1:0] T_MIN =
        $signed({{(X_W-T_W+1){1'b1}}, {(T_W-1){1'b0}}});
    localparam logic signed [X_W-1:0] T_MAX =
        $signed({{(X_W-T_W+1){1'b0}}, {(T_W-1){1'b1}}});

    logic [2:0] r_vld;
    logic [2:0] w_adv;

    // Stage D: squares and corrected temperature
    logic [RAW_W-1:0]         r_d_d1;
    logic signed [SQ_W-1:0]   r_d_xx;
    logic signed [SQ_W-1:0]   r_d_yy;
    logic signed [X_W-1:0]    r_d_temp;
    logic signed [OFF_W-1:0]  r_d_off1;
    logic signed [SENS_W-1:0] r_d_sens1;
    logic                     r_d_cold;
    logic                     r_d_vcold;
    logic signed [SQ_W-1:0]   n_d_xx;
    logic signed [SQ_W-1:0]   n_d_yy;
    logic signed [X_W-1:0]    n_d_temp;

    // Stage E: OFF2 and SENS2
    logic [RAW_W-1:0]         r_e_d1;
    logic signed [X_W-1:0]    r_e_temp;
    logic signed [OFF_W-1:0]  r_e_off1;
    logic signed [SENS_W-1:0] r_e_sens1;
    logic signed [SQ_W-1:0]   r_e_off2;
    logic signed [SQ_W-1:0]   r_e_sens2;
    logic signed [SQ_W-1:0]   n_e_off2;
    logic signed [SQ_W-1:0]   n_e_sens2;
    logic signed [SQ_W-1:0]   w_x5;
    logic signed [SQ_W-1:0]   w_y7;
    logic signed [SQ_W-1:0]   w_y11;

    // Stage F: corrected OFF and SENS
    t_so_word r_f;
    t_so_word n_f;

    always_comb begin
        w_adv[2] = !r_vld[2] || i_rdy;
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
    end

    assign o_rdy  = w_adv[0];
    assign o_vld  = r_vld[2];
    assign o_word = r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Square both deltas; subtract T2 only below 20.00 degC
    assign n_d_xx = i_word.x * i_word.x;
    assign n_d_yy = i_word.y * i_word.y;

    always_comb begin
        if (i_word.cold) begin
            n_d_temp = i_word.temp1 - i_word.t2;
        end else begin
            n_d_temp = i_word.temp1;
        end
    end

    // Constant multiples: 5*x^2, 7*y^2, 11*y^2 as shift-add
    assign w_x5  = (r_d_xx <<< 2) + r_d_xx;
    assign w_y7  = (r_d_yy <<< 3) - r_d_yy;
    assign w_y11 = (r_d_yy <<< 3) + (r_d_yy <<< 1) + r_d_yy;

    // Build OFF2 and SENS2; the extra term applies below -15.00 degC
    always_comb begin
        n_e_off2  = '0;
        n_e_sens2 = '0;
        if (r_d_cold) begin
            n_e_off2  = w_x5 >>> 1;
            n_e_sens2 = w_x5 >>> 2;
            if (r_d_vcold) begin
                n_e_off2  = (w_x5 >>> 1) + w_y7;
                n_e_sens2 = (w_x5 >>> 2) + (w_y11 >>> 1);
            end
        end
    end

    always_comb begin
        n_f.d1   = r_e_d1;
        n_f.temp = r_e_temp;
        n_f.off  = r_e_off1 - OFF_W'(r_e_off2);
        n_f.sens = r_e_sens1 - SENS_W'(r_e_sens2);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_d_d1    <= i_word.d1;
            r_d_xx    <= n_d_xx;
            r_d_yy    <= n_d_yy;
            r_d_temp  <= n_d_temp;
            r_d_off1  <= i_word.off1;
            r_d_sens1 <= i_word.sens1;
            r_d_cold  <= i_word.cold;
            r_d_vcold <= i_word.vcold;
        end
        if (w_adv[1]) begin
            r_e_d1    <= r_d_d1;
            r_e_temp  <= r_d_temp;
            r_e_off1  <= r_d_off1;
            r_e_sens1 <= r_d_sens1;
            r_e_off2  <= n_e_off2;
            r_e_sens2 <= n_e_sens2;
        end
        if (w_adv[2]) begin
            r_f <= n_f;
        end
    end

    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_d_temp >= T_MIN) && (r_d_temp <= T_MAX))
        else $error("corrected temperature outside the output field");

endmodule

`default_nettype wire

/* rtl/bpc_pressure.sv */
// Pressure section: D1 * SENS as two partial products, scaling, offset
// removal and saturation into the output register. Four register stages.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpc_pressure (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_vld,
    output logic                      o_rdy,
    input  bpc_pkg::t_so_word         i_word,
    output logic                      o_vld,
    input  logic                      i_rdy,
    output logic signed [bpc_pkg::P_W-1:0] o_pressure,
    output logic signed [bpc_pkg::T_W-1:0] o_temperature
);
    import bpc_pkg::*;

    localparam logic signed [Q_W-1:0] P_MAX =
        $signed({{(Q_W-P_W+1){1'b0}}, {(P_W-1){1'b1}}});
    localparam logic signed [Q_W-1:0] P_MIN =
        $signed({{(Q_W-P_W+1){1'b1}}, {(P_W-1){1'b0}}});

    logic [3:0] r_vld;
    logic [3:0] w_adv;

    // Stage G: partial products
    logic [PL_W-1:0]          r_g_pl;
    logic signed [PH_W-1:0]   r_g_ph;
    logic signed [OFF_W-1:0]  r_g_off;
    logic signed [X_W-1:0]    r_g_temp;
    logic [PL_W-1:0]          n_g_pl;
    logic signed [PH_W-1:0]   n_g_ph;

    // Stage H: full product
    logic signed [PROD_W-1:0] r_h_prod;
    logic signed [OFF_W-1:0]  r_h_off;
    logic signed [X_W-1:0]    r_h_temp;
    logic signed [PROD_W-1:0] n_h_prod;

    // Stage I: scaled product minus offset
    logic signed [Q_W-1:0]    r_i_q;
    logic signed [X_W-1:0]    r_i_temp;
    logic signed [Q_W-1:0]    n_i_q;

    // Stage J: output register
    logic signed [P_W-1:0]    r_o_pressure;
    logic signed [T_W-1:0]    r_o_temp;
    logic signed [P_W-1:0]    n_o_pressure;
    logic signed [Q_W-1:0]    w_pfull;

    always_comb begin
        w_adv[3] = !r_vld[3] || i_rdy;
        w_adv[2] = !r_vld[2] || w_adv[3];
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
    end

    assign o_rdy         = w_adv[0];
    assign o_vld         = r_vld[3];
    assign o_pressure    = r_o_pressure;
    assign o_temperature = r_o_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_vld;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    // Split SENS into an unsigned low part and a signed high part
    assign n_g_pl = i_word.d1 * i_word.sens[SPLIT-1:0];
    assign n_g_ph = $signed({1'b0, i_word.d1}) * $signed(i_word.sens[SENS_W-1:SPLIT]);

    // Recombine the partial products
    assign n_h_prod = PROD_W'($signed({r_g_ph, {SPLIT{1'b0}}}) + $signed({1'b0, r_g_pl}));

    // D1 * SENS / 2^21 - OFF
    assign n_i_q = Q_W'(r_h_prod >>> SH_PSENS)
                 - $signed({{(Q_W-OFF_W){r_h_off[OFF_W-1]}}, r_h_off});

    // Divide by 2^15 and clamp to the signed 32-bit range
    assign w_pfull = r_i_q >>> SH_POUT;

    always_comb begin
        if (w_pfull > P_MAX) begin
            n_o_pressure = P_W'(P_MAX);
        end else if (w_pfull < P_MIN) begin
            n_o_pressure = P_W'(P_MIN);
        end else begin
            n_o_pressure = P_W'(w_pfull);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_g_pl   <= n_g_pl;
            r_g_ph   <= n_g_ph;
            r_g_off  <= i_word.off;
            r_g_temp <= i_word.temp;
        end
        if (w_adv[1]) begin
            r_h_prod <= n_h_prod;
            r_h_off  <= r_g_off;
            r_h_temp <= r_g_temp;
        end
        if (w_adv[2]) begin
            r_i_q    <= n_i_q;
            r_i_temp <= r_h_temp;
        end
        if (w_adv[3]) begin
            r_o_pressure <= n_o_pressure;
            r_o_temp     <= r_i_temp[T_W-1:0];
        end
    end

    a_hold_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !w_adv[1] |=> r_vld[1])
        else $error("stalled product word dropped");

endmodule

`default_nettype wire
